### design/tdia_pkg.sv
// Shared constants, codes and structure types of the typed dense index allocator.
// Depends on nothing; every other design file imports it.
package tdia_pkg;

   // Sizing of the tables.
   localparam int NUM_TYPES   = 11;
   localparam int MAX_ENTRIES = 256;
   localparam int MAX_BLOCKS  = 64;
   localparam int MAX_DIM     = 64;
   localparam int INDEX_WIDTH = 16;

   // Channel field widths.
   localparam int KIND_W        = 2;
   localparam int VAR_TYPE_W    = 4;
   localparam int ENTRY_INDEX_W = 12;
   localparam int BLOCK_ID_W    = 8;
   localparam int BLOCK_DIM_W   = 7;
   localparam int STATUS_W      = 3;

   // Derived sizes.
   localparam int ENTRY_SLOTS = NUM_TYPES * MAX_ENTRIES;
   localparam int ENTRY_AW    = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
   localparam int SWEEP_W     = $clog2(ENTRY_SLOTS + 1);
   localparam int BLOCK_AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int TYPE_AW     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int SIZE_W      = $clog2(MAX_ENTRIES + 1);
   localparam int LEN_W       = $clog2(MAX_DIM + 1);

   // The counter never hands out this value.
   localparam logic [INDEX_WIDTH-1:0] INDEX_LIMIT = {INDEX_WIDTH{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTER = 2'd0,
      KIND_LOOKUP   = 2'd1,
      KIND_BLOCK    = 2'd2,
      KIND_CLEAR    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_SIZE     = 3'd1,
      STAT_TYPE     = 3'd2,
      STAT_CAPACITY = 3'd3,
      STAT_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic                   present;
      logic                   assigned;
      logic [INDEX_WIDTH-1:0] dense_index;
   } entry_word_type;

   typedef struct packed {
      logic                wr_en;
      logic [ENTRY_AW-1:0] wr_addr;
      entry_word_type      wr_data;
      logic [ENTRY_AW-1:0] rd_addr;
   } entry_mem_ctl_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] base;
      logic [LEN_W-1:0]       len;
   } block_word_type;

   typedef struct packed {
      logic                wr_en;
      logic [BLOCK_AW-1:0] wr_addr;
      block_word_type      wr_data;
      logic [BLOCK_AW-1:0] rd_addr;
   } block_mem_ctl_type;

   typedef struct packed {
      logic           present;
      block_word_type word;
   } block_rd_type;

   typedef struct packed {
      logic                   created;
      status_type             status;
      logic [INDEX_WIDTH-1:0] dense_index;
      logic                   index_valid;
      logic                   last;
   } result_type;

endpackage

### design/tdia_chan_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on tdia_pkg for the field widths.
interface tdia_req_if import tdia_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [VAR_TYPE_W-1:0]    var_type;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic [BLOCK_ID_W-1:0]    block_id;
   logic [BLOCK_DIM_W-1:0]   block_dim;

   modport source (output valid, kind, var_type, entry_index, block_id, block_dim,
                   input ready);
   modport sink   (input valid, kind, var_type, entry_index, block_id, block_dim,
                   output ready);
endinterface

interface tdia_rsp_if import tdia_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   created;
   logic [STATUS_W-1:0]    status;
   logic [INDEX_WIDTH-1:0] dense_index;
   logic                   index_valid;
   logic                   last;

   modport source (output valid, created, status, dense_index, index_valid, last,
                   input ready);
   modport sink   (input valid, created, status, dense_index, index_valid, last,
                   output ready);
endinterface

### design/tdia_entry_mem.sv
// Entry store: one word per typed table entry (registered, assigned, dense index).
// Simple dual-port memory with a registered read. Depends on tdia_pkg.
module tdia_entry_mem import tdia_pkg::*; (
   input  logic              clock,
   input  entry_mem_ctl_type ctl,
   output entry_word_type    rd_data
);

   entry_word_type mem [ENTRY_SLOTS];
   entry_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tdia_block_mem.sv
// Expression block store: base and length per block, with a present bit per block
// kept in flip-flops that reset clears. Depends on tdia_pkg.
module tdia_block_mem import tdia_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  block_mem_ctl_type ctl,
   output block_rd_type      rd_data
);

   block_word_type          mem [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0]   present_ff;
   block_rd_type            rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
      end else if (ctl.wr_en) begin
         present_ff[ctl.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff.word    <= mem[ctl.rd_addr];
      rd_data_ff.present <= present_ff[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tdia_ctrl.sv
// Sequencer of the allocator: accepts an item, reads the stores, decides, writes
// back and emits results; also runs the clearing sweep. Depends on tdia_pkg and
// the channel interfaces.
module tdia_ctrl import tdia_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tdia_req_if.sink          req,
   tdia_rsp_if.source        rsp,
   output entry_mem_ctl_type entry_ctl,
   input  entry_word_type    entry_rd,
   output block_mem_ctl_type block_ctl,
   input  block_rd_type      block_rd
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_LOOK,
      S_EMIT,
      S_RUN
   } state_type;

   state_type                state_ff, state_in;
   kind_type                 kind_ff, kind_in;
   logic [VAR_TYPE_W-1:0]    vt_ff, vt_in;
   logic [ENTRY_INDEX_W-1:0] ei_ff, ei_in;
   logic [BLOCK_ID_W-1:0]    bid_ff, bid_in;
   logic [BLOCK_DIM_W-1:0]   bdim_ff, bdim_in;
   logic [ENTRY_AW-1:0]      slot_ff, slot_in;
   logic [INDEX_WIDTH-1:0]   next_ff, next_in;
   logic [SIZE_W-1:0]        size_ff [NUM_TYPES];
   logic [SIZE_W-1:0]        size_in [NUM_TYPES];
   logic [SWEEP_W-1:0]       sweep_cnt_ff, sweep_cnt_in;
   logic                     sweep_pipe_ff, sweep_pipe_in;
   logic [ENTRY_AW-1:0]      sweep_addr_ff, sweep_addr_in;
   logic                     sweep_full_ff, sweep_full_in;
   result_type               pend_ff, pend_in;
   logic [INDEX_WIDTH-1:0]   run_base_ff, run_base_in;
   logic [LEN_W-1:0]         run_len_ff, run_len_in;
   logic [LEN_W-1:0]         run_k_ff, run_k_in;
   logic                     run_cr_ff, run_cr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               out_ff, out_in;

   logic                     out_free;

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin : next_state
      result_type             res;
      logic                   emit_one;
      logic                   blk_ok;
      logic                   blk_cr;
      logic [INDEX_WIDTH-1:0] blk_base;
      logic [LEN_W-1:0]       blk_len;
      logic [SIZE_W-1:0]      cur_size;
      logic [TYPE_AW-1:0]     vt_idx;
      logic                   run_last;

      state_in      = state_ff;
      kind_in       = kind_ff;
      vt_in         = vt_ff;
      ei_in         = ei_ff;
      bid_in        = bid_ff;
      bdim_in       = bdim_ff;
      slot_in       = slot_ff;
      next_in       = next_ff;
      size_in       = size_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sweep_pipe_in = sweep_pipe_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_full_in = sweep_full_ff;
      pend_in       = pend_ff;
      run_base_in   = run_base_ff;
      run_len_in    = run_len_ff;
      run_k_in      = run_k_ff;
      run_cr_in     = run_cr_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      res.created     = 1'b0;
      res.status      = STAT_OK;
      res.dense_index = '0;
      res.index_valid = 1'b0;
      res.last        = 1'b1;
      emit_one        = 1'b0;
      blk_ok          = 1'b0;
      blk_cr          = 1'b0;
      blk_base        = block_rd.word.base;
      blk_len         = block_rd.word.len;
      vt_idx          = vt_ff[TYPE_AW-1:0];
      cur_size        = size_ff[vt_idx];
      run_last        = (LEN_W'(run_k_ff + 1'b1) == run_len_ff);

      entry_ctl.wr_en   = 1'b0;
      entry_ctl.wr_addr = slot_ff;
      entry_ctl.wr_data = entry_rd;
      entry_ctl.rd_addr = ENTRY_AW'(32'(req.var_type) * MAX_ENTRIES
                                    + 32'(req.entry_index));
      block_ctl.wr_en        = 1'b0;
      block_ctl.wr_addr      = bid_ff[BLOCK_AW-1:0];
      block_ctl.wr_data.base = next_ff;
      block_ctl.wr_data.len  = LEN_W'(bdim_ff);
      block_ctl.rd_addr      = req.block_id[BLOCK_AW-1:0];

      unique case (state_ff)
         S_SWEEP: begin
            // Read one entry a cycle and write it back in the next cycle with the
            // assignment dropped; after reset the registration goes as well.
            entry_ctl.rd_addr = sweep_cnt_ff[ENTRY_AW-1:0];
            if (sweep_cnt_ff != SWEEP_W'(ENTRY_SLOTS)) begin
               sweep_cnt_in  = SWEEP_W'(sweep_cnt_ff + 1'b1);
               sweep_pipe_in = 1'b1;
               sweep_addr_in = sweep_cnt_ff[ENTRY_AW-1:0];
            end else begin
               sweep_pipe_in = 1'b0;
               if (!sweep_pipe_ff) begin
                  state_in = sweep_full_ff ? S_IDLE : S_EMIT;
               end
            end
            if (sweep_pipe_ff) begin
               entry_ctl.wr_en                = 1'b1;
               entry_ctl.wr_addr              = sweep_addr_ff;
               entry_ctl.wr_data.present      = entry_rd.present && !sweep_full_ff;
               entry_ctl.wr_data.assigned     = 1'b0;
               entry_ctl.wr_data.dense_index  = entry_rd.dense_index;
            end
         end

         S_IDLE: begin
            if (req.valid) begin
               kind_in  = kind_type'(req.kind);
               vt_in    = req.var_type;
               ei_in    = req.entry_index;
               bid_in   = req.block_id;
               bdim_in  = req.block_dim;
               slot_in  = entry_ctl.rd_addr;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            case (kind_ff)
               KIND_CLEAR: begin
                  next_in       = '0;
                  sweep_cnt_in  = '0;
                  sweep_pipe_in = 1'b0;
                  sweep_full_in = 1'b0;
                  pend_in       = res;
                  state_in      = S_SWEEP;
               end

               KIND_BLOCK: begin
                  if (32'(bid_ff) >= 32'(MAX_BLOCKS)) begin
                     res.status = STAT_CAPACITY;
                     emit_one   = 1'b1;
                  end else if (!block_rd.present) begin
                     if (32'(bdim_ff) > 32'(MAX_DIM)) begin
                        res.status = STAT_CAPACITY;
                        emit_one   = 1'b1;
                     end else if ((INDEX_WIDTH+1)'(next_ff) + (INDEX_WIDTH+1)'(bdim_ff)
                                  > (INDEX_WIDTH+1)'(INDEX_LIMIT)) begin
                        res.status = STAT_OVERFLOW;
                        emit_one   = 1'b1;
                     end else begin
                        block_ctl.wr_en = 1'b1;
                        next_in  = INDEX_WIDTH'(next_ff + INDEX_WIDTH'(bdim_ff));
                        blk_ok   = 1'b1;
                        blk_cr   = 1'b1;
                        blk_base = next_ff;
                        blk_len  = LEN_W'(bdim_ff);
                     end
                  end else begin
                     blk_ok = 1'b1;
                  end
                  if (blk_ok) begin
                     if (blk_len == '0) begin
                        res.created = blk_cr;
                        emit_one    = 1'b1;
                     end else begin
                        run_base_in = blk_base;
                        run_len_in  = blk_len;
                        run_k_in    = '0;
                        run_cr_in   = blk_cr;
                        state_in    = S_RUN;
                     end
                  end
               end

               default: begin
                  emit_one = 1'b1;
                  if (32'(vt_ff) >= 32'(NUM_TYPES)) begin
                     res.status = STAT_TYPE;
                  end else if (kind_ff == KIND_REGISTER) begin
                     if (32'(ei_ff) >= 32'(MAX_ENTRIES)) begin
                        res.status = STAT_CAPACITY;
                     end else begin
                        if (ei_ff >= ENTRY_INDEX_W'(cur_size)) begin
                           size_in[vt_idx] = SIZE_W'(ei_ff + 1'b1);
                        end
                        if (!entry_rd.present) begin
                           entry_ctl.wr_en           = 1'b1;
                           entry_ctl.wr_data.present = 1'b1;
                           res.created               = 1'b1;
                        end
                     end
                  end else begin
                     if (ei_ff >= ENTRY_INDEX_W'(cur_size)
                         || 32'(ei_ff) >= 32'(MAX_ENTRIES)) begin
                        res.status = STAT_SIZE;
                     end else if (!entry_rd.assigned) begin
                        if (next_ff >= INDEX_LIMIT) begin
                           res.status = STAT_OVERFLOW;
                        end else begin
                           entry_ctl.wr_en               = 1'b1;
                           entry_ctl.wr_data.assigned    = 1'b1;
                           entry_ctl.wr_data.dense_index = next_ff;
                           next_in         = INDEX_WIDTH'(next_ff + 1'b1);
                           res.dense_index = next_ff;
                           res.index_valid = 1'b1;
                        end
                     end else begin
                        res.dense_index = entry_rd.dense_index;
                        res.index_valid = 1'b1;
                     end
                  end
               end
            endcase

            if (emit_one) begin
               if (out_free) begin
                  out_in       = res;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  pend_in  = res;
                  state_in = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            if (out_free) begin
               out_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         S_RUN: begin
            if (out_free) begin
               out_in.created     = run_cr_ff;
               out_in.status      = STAT_OK;
               out_in.dense_index = INDEX_WIDTH'(run_base_ff + INDEX_WIDTH'(run_k_ff));
               out_in.index_valid = 1'b1;
               out_in.last        = run_last;
               rsp_valid_in       = 1'b1;
               run_k_in           = LEN_W'(run_k_ff + 1'b1);
               if (run_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         next_ff       <= '0;
         sweep_cnt_ff  <= '0;
         sweep_pipe_ff <= 1'b0;
         sweep_full_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            size_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         next_ff       <= next_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         sweep_pipe_ff <= sweep_pipe_in;
         sweep_full_ff <= sweep_full_in;
         rsp_valid_ff  <= rsp_valid_in;
         size_ff       <= size_in;
      end
      kind_ff       <= kind_in;
      vt_ff         <= vt_in;
      ei_ff         <= ei_in;
      bid_ff        <= bid_in;
      bdim_ff       <= bdim_in;
      slot_ff       <= slot_in;
      sweep_addr_ff <= sweep_addr_in;
      pend_ff       <= pend_in;
      run_base_ff   <= run_base_in;
      run_len_ff    <= run_len_in;
      run_k_ff      <= run_k_in;
      run_cr_ff     <= run_cr_in;
      out_ff        <= out_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.created     = out_ff.created;
   assign rsp.status      = out_ff.status;
   assign rsp.dense_index = out_ff.dense_index;
   assign rsp.index_valid = out_ff.index_valid;
   assign rsp.last        = out_ff.last;

endmodule

### design/typed_dense_index_allocator_unit.sv
// Top level of the typed dense index allocator: sequencer plus entry and block stores.
// Depends on tdia_pkg, the channel interfaces, tdia_ctrl, tdia_entry_mem, tdia_block_mem.
//
//   channel   direction   fields
//   req_ch    in          kind, var_type, entry_index, block_id, block_dim
//   rsp_ch    out         created, status, dense_index, index_valid, last
//
// An item that gives one result is handled in the accept cycle, which addresses the
// stores, and then in the cycle that sees the registered read data, decides and writes back.
// An expression block run gives one result a cycle while the output register is free.
// A clear sweeps the entry store one entry a cycle.
// After reset the same sweep runs over the entry store with req_ch.ready low.
// A stalled response holds in the output register; the next item is taken meanwhile.
module typed_dense_index_allocator_unit import tdia_pkg::*; (
   input logic        clock,
   input logic        reset,
   tdia_req_if.sink   req_ch,
   tdia_rsp_if.source rsp_ch
);

   entry_mem_ctl_type entry_ctl;
   entry_word_type    entry_rd;
   block_mem_ctl_type block_ctl;
   block_rd_type      block_rd;

   tdia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .entry_ctl (entry_ctl),
      .entry_rd  (entry_rd),
      .block_ctl (block_ctl),
      .block_rd  (block_rd)
   );

   tdia_entry_mem u_entry_mem (
      .clock   (clock),
      .ctl     (entry_ctl),
      .rd_data (entry_rd)
   );

   tdia_block_mem u_block_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (block_ctl),
      .rd_data (block_rd)
   );

endmodule

### sim/typed_dense_index_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the typed dense index allocator: directed and random items,
// a scoreboard class that predicts every result, random stalls on both channels.
// Depends on tdia_pkg, the channel interfaces and typed_dense_index_allocator_unit.

import tdia_pkg::*;

typedef struct packed {
   kind_type                 kind;
   logic [VAR_TYPE_W-1:0]    var_type;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic [BLOCK_ID_W-1:0]    block_id;
   logic [BLOCK_DIM_W-1:0]   block_dim;
} alloc_req_type;

class allocator_scoreboard;
   logic [SIZE_W-1:0]      type_size [NUM_TYPES];
   bit                     entry_present [ENTRY_SLOTS];
   bit                     entry_assigned [ENTRY_SLOTS];
   logic [INDEX_WIDTH-1:0] entry_dense [ENTRY_SLOTS];
   logic [INDEX_WIDTH-1:0] counter;
   bit                     block_present [MAX_BLOCKS];
   logic [INDEX_WIDTH-1:0] block_base [MAX_BLOCKS];
   logic [BLOCK_DIM_W-1:0] block_len [MAX_BLOCKS];
   result_type             results_due [$];
   int                     errors;

   function new();
      foreach (type_size[t]) type_size[t] = '0;
      foreach (entry_dense[s]) entry_dense[s] = '0;
      foreach (block_base[b]) begin
         block_base[b] = '0;
         block_len[b]  = '0;
      end
      counter = '0;
      errors  = 0;
   endfunction

   function int pending();
      return results_due.size();
   endfunction

   function void push(bit created, status_type status, logic [INDEX_WIDTH-1:0] idx,
                      bit valid, bit last);
      result_type res;
      res.created     = created;
      res.status      = status;
      res.dense_index = idx;
      res.index_valid = valid;
      res.last        = last;
      results_due.push_back(res);
   endfunction

   // Works out the results of one accepted item and updates the tables.
   function void predict_allocation(alloc_req_type r);
      int slot;
      int len;
      bit cr;
      case (r.kind)
         KIND_CLEAR: begin
            foreach (entry_assigned[s]) entry_assigned[s] = 1'b0;
            counter = '0;
            push(1'b0, STAT_OK, '0, 1'b0, 1'b1);
         end
         KIND_BLOCK: begin
            if (r.block_id >= MAX_BLOCKS) begin
               push(1'b0, STAT_CAPACITY, '0, 1'b0, 1'b1);
               return;
            end
            cr = 1'b0;
            if (!block_present[r.block_id]) begin
               if (r.block_dim > MAX_DIM) begin
                  push(1'b0, STAT_CAPACITY, '0, 1'b0, 1'b1);
                  return;
               end
               if (int'(counter) + int'(r.block_dim) > int'(INDEX_LIMIT)) begin
                  push(1'b0, STAT_OVERFLOW, '0, 1'b0, 1'b1);
                  return;
               end
               block_present[r.block_id] = 1'b1;
               block_base[r.block_id]    = counter;
               block_len[r.block_id]     = r.block_dim;
               counter = counter + r.block_dim;
               cr = 1'b1;
            end
            // A present block replays its stored run whatever the dimension says.
            len = int'(block_len[r.block_id]);
            if (len == 0)
               push(cr, STAT_OK, '0, 1'b0, 1'b1);
            else
               for (int k = 0; k < len; k++)
                  push(cr, STAT_OK, INDEX_WIDTH'(block_base[r.block_id] + k), 1'b1,
                       k == len - 1);
         end
         default: begin
            if (r.var_type >= NUM_TYPES) begin
               push(1'b0, STAT_TYPE, '0, 1'b0, 1'b1);
               return;
            end
            slot = r.var_type * MAX_ENTRIES + r.entry_index;
            if (r.kind == KIND_REGISTER) begin
               if (r.entry_index >= MAX_ENTRIES) begin
                  push(1'b0, STAT_CAPACITY, '0, 1'b0, 1'b1);
                  return;
               end
               if (r.entry_index >= type_size[r.var_type])
                  type_size[r.var_type] = SIZE_W'(r.entry_index + 1);
               push(!entry_present[slot], STAT_OK, '0, 1'b0, 1'b1);
               entry_present[slot] = 1'b1;
            end else begin
               if (r.entry_index >= type_size[r.var_type] || r.entry_index >= MAX_ENTRIES) begin
                  push(1'b0, STAT_SIZE, '0, 1'b0, 1'b1);
                  return;
               end
               if (!entry_assigned[slot]) begin
                  if (counter >= INDEX_LIMIT) begin
                     push(1'b0, STAT_OVERFLOW, '0, 1'b0, 1'b1);
                     return;
                  end
                  entry_assigned[slot] = 1'b1;
                  entry_dense[slot]    = counter;
                  counter = counter + 1'b1;
               end
               push(1'b0, STAT_OK, entry_dense[slot], 1'b1, 1'b1);
            end
         end
      endcase
   endfunction

   function void note_request(alloc_req_type r);
      predict_allocation(r);
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(result_type got);
      result_type want;
      if (results_due.size() == 0) begin
         report("result arrived with nothing due");
         return;
      end
      want = results_due.pop_front();
      if (got.created !== want.created)
         report($sformatf("created got %0b want %0b", got.created, want.created));
      if (got.status !== want.status)
         report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.dense_index !== want.dense_index)
         report($sformatf("dense_index got %0d want %0d", got.dense_index, want.dense_index));
      if (got.index_valid !== want.index_valid)
         report($sformatf("index_valid got %0b want %0b", got.index_valid, want.index_valid));
      if (got.last !== want.last)
         report($sformatf("last got %0b want %0b", got.last, want.last));
   endtask
endclass

module typed_dense_index_allocator_unit_tb;
   localparam int STALL_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 3000;
   localparam int RANDOM_ITEMS  = 385;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm;
   bit   hold_rsp;
   int   quiet_cycles;
   allocator_scoreboard sb;

   tdia_req_if req_ch ();
   tdia_rsp_if rsp_ch ();

   typed_dense_index_allocator_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic alloc_req_type make_req(kind_type k, int vt, int ei, int bid, int bdim);
      alloc_req_type r;
      r.kind        = k;
      r.var_type    = VAR_TYPE_W'(vt);
      r.entry_index = ENTRY_INDEX_W'(ei);
      r.block_id    = BLOCK_ID_W'(bid);
      r.block_dim   = BLOCK_DIM_W'(bdim);
      return r;
   endfunction

   function automatic alloc_req_type random_request();
      alloc_req_type r;
      int roll;
      roll = $urandom_range(99);
      if (roll < 32)      r.kind = KIND_REGISTER;
      else if (roll < 67) r.kind = KIND_LOOKUP;
      else if (roll < 97) r.kind = KIND_BLOCK;
      else                r.kind = KIND_CLEAR;
      r.var_type = VAR_TYPE_W'(($urandom_range(99) < 85) ? $urandom_range(NUM_TYPES - 1)
                                                         : $urandom_range(15));
      roll = $urandom_range(99);
      // Small entry numbers keep hitting entries that already exist.
      if (roll < 70)      r.entry_index = ENTRY_INDEX_W'($urandom_range(47));
      else if (roll < 88) r.entry_index = ENTRY_INDEX_W'($urandom_range(MAX_ENTRIES - 1));
      else                r.entry_index = ENTRY_INDEX_W'($urandom_range(4095));
      r.block_id  = BLOCK_ID_W'(($urandom_range(99) < 88) ? $urandom_range(MAX_BLOCKS - 1)
                                                          : $urandom_range(255));
      r.block_dim = BLOCK_DIM_W'(($urandom_range(99) < 80) ? $urandom_range(MAX_DIM)
                                                           : $urandom_range(127));
      return r;
   endfunction

   // Offers one item from a falling edge and returns at the rising edge that takes it.
   task send_item(alloc_req_type r);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 12) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.kind        = r.kind;
      req_ch.var_type    = r.var_type;
      req_ch.entry_index = r.entry_index;
      req_ch.block_id    = r.block_id;
      req_ch.block_dim   = r.block_dim;
      req_ch.valid       = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task pause_until_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Result receiver; a hold request keeps ready low long enough to back up the input.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp     = 1'b0;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready = calm || ($urandom_range(99) >= 12);
      end
   end

   // Samples both channels and ends the run when nothing moves for too long.
   always @(posedge clock) begin
      alloc_req_type seen;
      result_type got;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.kind        = kind_type'(req_ch.kind);
            seen.var_type    = req_ch.var_type;
            seen.entry_index = req_ch.entry_index;
            seen.block_id    = req_ch.block_id;
            seen.block_dim   = req_ch.block_dim;
            sb.note_request(seen);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.created     = rsp_ch.created;
            got.status      = status_type'(rsp_ch.status);
            got.dense_index = rsp_ch.dense_index;
            got.index_valid = rsp_ch.index_valid;
            got.last        = rsp_ch.last;
            sb.check_result(got);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      alloc_req_type r;
      sb                 = new();
      calm               = 1'b0;
      hold_rsp           = 1'b0;
      quiet_cycles       = 0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = '0;
      req_ch.var_type    = '0;
      req_ch.entry_index = '0;
      req_ch.block_id    = '0;
      req_ch.block_dim   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: registration, growth, lookups, bad types, capacity limits, blocks and a clear.
      send_item(make_req(KIND_REGISTER, 0, 0, 0, 0));
      send_item(make_req(KIND_REGISTER, 0, 0, 0, 0));
      send_item(make_req(KIND_REGISTER, NUM_TYPES - 1, MAX_ENTRIES - 1, 255, 127));
      send_item(make_req(KIND_REGISTER, NUM_TYPES - 1, MAX_ENTRIES, 0, 0));
      send_item(make_req(KIND_REGISTER, 15, 4095, 0, 0));
      send_item(make_req(KIND_REGISTER, NUM_TYPES, 3, 0, 0));
      send_item(make_req(KIND_LOOKUP, 0, 0, 0, 0));
      send_item(make_req(KIND_LOOKUP, 0, 0, 0, 0));
      // Inside the grown size but never registered: still gets an index.
      send_item(make_req(KIND_LOOKUP, NUM_TYPES - 1, 100, 0, 0));
      send_item(make_req(KIND_LOOKUP, 1, 0, 0, 0));
      send_item(make_req(KIND_LOOKUP, NUM_TYPES - 1, 4095, 0, 0));
      send_item(make_req(KIND_LOOKUP, 12, 0, 0, 0));
      send_item(make_req(KIND_BLOCK, 0, 0, 0, MAX_DIM));
      send_item(make_req(KIND_BLOCK, 0, 0, 0, 5));
      send_item(make_req(KIND_BLOCK, 0, 0, 1, 0));
      send_item(make_req(KIND_BLOCK, 0, 0, 1, 9));
      send_item(make_req(KIND_BLOCK, 0, 0, 2, MAX_DIM + 1));
      send_item(make_req(KIND_BLOCK, 0, 0, 2, 127));
      send_item(make_req(KIND_BLOCK, 0, 0, MAX_BLOCKS, 1));
      send_item(make_req(KIND_BLOCK, 15, 4095, 255, 127));
      send_item(make_req(KIND_BLOCK, 0, 0, MAX_BLOCKS - 1, 1));
      send_item(make_req(KIND_CLEAR, 0, 0, 0, 0));
      send_item(make_req(KIND_LOOKUP, 0, 0, 0, 0));
      send_item(make_req(KIND_BLOCK, 0, 0, 0, 3));
      send_item(make_req(KIND_REGISTER, 5, 171, 0, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100)
            hold_rsp = 1'b1;
         if (n == 250)
            pause_until_drained();
         calm = (n >= 300 && n < 380);
         r = random_request();
         send_item(r);
         // Often look up what was just registered, so lookups get past the size check.
         if (r.kind == KIND_REGISTER && $urandom_range(99) < 40) begin
            r.kind = KIND_LOOKUP;
            send_item(r);
         end
      end

      pause_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
